// ===== hdl/pbl_pkg.sv =====
// Shared widths, payload structs, register indexes and cell data for the belt length block.
`default_nettype none
package pbl_pkg;

	localparam int POS_BITS = 24;
	localparam int LEN_BITS = POS_BITS + 1;
	localparam int SQ_BITS  = 2 * LEN_BITS;
	localparam int REM_BITS = LEN_BITS + 2;
	localparam int IDX_BITS = 2;

	// floor(sqrt(2) * 2^POS_BITS): longest belt when both offsets are at full scale
	localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(23726566);

	typedef enum logic [IDX_BITS-1:0] {
		REG_LEFT_EDGE_X  = 2'd0,
		REG_RIGHT_EDGE_X = 2'd1,
		REG_TOP_EDGE_Y   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] target_x;
		logic signed [POS_BITS-1:0] target_y;
		logic signed [POS_BITS-1:0] target_z;
	} target_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]        left_belt_length;
		logic [LEN_BITS-1:0]        right_belt_length;
		logic signed [POS_BITS-1:0] out_z;
	} result_t;

	// One square root in flight: radicand bits still to consume, partial remainder, partial root
	typedef struct packed {
		logic [SQ_BITS-1:0]  rad;
		logic [REM_BITS-1:0] rem;
		logic [LEN_BITS-1:0] root;
	} root_lane_t;

	typedef struct packed {
		root_lane_t          left;
		root_lane_t          right;
		logic [POS_BITS-1:0] z;
	} cell_data_t;

endpackage
`default_nettype wire

// ===== hdl/pbl_front.sv =====
// Front stages: anchor offsets and their squares, then the two radicands.
`default_nettype none
module pbl_front import pbl_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [POS_BITS-1:0] left_edge_x,
	input  wire logic [POS_BITS-1:0] right_edge_x,
	input  wire logic [POS_BITS-1:0] top_edge_y,
	input  wire logic                up_valid,
	output logic                     up_ready,
	input  wire target_t             up_data,
	output logic                     dn_valid,
	input  wire logic                dn_ready,
	output cell_data_t               dn_data
);

	logic signed [LEN_BITS-1:0] dl, dr, dy;
	logic [LEN_BITS-1:0]        ml, mr, my;
	logic                       valid_s1, valid_s2;
	logic                       ready_s1, ready_s2;
	logic [SQ_BITS-1:0]         sq_l_s1, sq_r_s1, sq_y_s1;
	logic [POS_BITS-1:0]        z_s1;
	logic [SQ_BITS:0]           sum_l, sum_r;
	cell_data_t                 data_s2;

	always_comb begin
		dl = {up_data.target_x[POS_BITS-1], up_data.target_x}
			- {left_edge_x[POS_BITS-1], left_edge_x};
		dr = {right_edge_x[POS_BITS-1], right_edge_x}
			- {up_data.target_x[POS_BITS-1], up_data.target_x};
		dy = {up_data.target_y[POS_BITS-1], up_data.target_y}
			- {top_edge_y[POS_BITS-1], top_edge_y};
		// magnitude of a LEN_BITS signed value never exceeds 2^POS_BITS, so it fits unsigned
		ml = dl[LEN_BITS-1] ? LEN_BITS'(-dl) : LEN_BITS'(dl);
		mr = dr[LEN_BITS-1] ? LEN_BITS'(-dr) : LEN_BITS'(dr);
		my = dy[LEN_BITS-1] ? LEN_BITS'(-dy) : LEN_BITS'(dy);
	end

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= up_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			sq_l_s1 <= ml * ml;
			sq_r_s1 <= mr * mr;
			sq_y_s1 <= my * my;
			z_s1    <= up_data.target_z;
		end
		if (ready_s2 && valid_s1)
			data_s2 <= '{
				left:  '{rad: sum_l[SQ_BITS-1:0], rem: '0, root: '0},
				right: '{rad: sum_r[SQ_BITS-1:0], rem: '0, root: '0},
				z:     z_s1
			};
	end

	// each square is at most 2^(2*POS_BITS), so the sum stays below 2^SQ_BITS
	assign sum_l = {1'b0, sq_l_s1} + {1'b0, sq_y_s1};
	assign sum_r = {1'b0, sq_r_s1} + {1'b0, sq_y_s1};

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule
`default_nettype wire

// ===== hdl/pbl_cell.sv =====
// One root cell: settles one bit of both belt lengths and hands the word on.
`default_nettype none
module pbl_cell import pbl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	output logic            up_ready,
	input  wire cell_data_t up_data,
	output logic            dn_valid,
	input  wire logic       dn_ready,
	output cell_data_t      dn_data
);

	function automatic root_lane_t root_step(input root_lane_t a);
		logic [REM_BITS-1:0] cur;
		logic [REM_BITS-1:0] trial;
		root_lane_t          r;
		// bring down the next radicand pair and try root*4+1 against it
		cur   = {a.rem[REM_BITS-3:0], a.rad[SQ_BITS-1 -: 2]};
		trial = {1'b0, a.root[LEN_BITS-2:0], 2'b01};
		r.rad = {a.rad[SQ_BITS-3:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[LEN_BITS-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[LEN_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic       valid_q;
	cell_data_t data_q;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (up_ready)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.left  <= root_step(up_data.left);
			data_q.right <= root_step(up_data.right);
			data_q.z     <= up_data.z;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

// ===== hdl/polargraph_belt_lengths.sv =====
// Top level: anchor registers, front stages and the row of root cells.
//
//   channel   direction  handshake                 word
//   target    in         target_valid/target_ready target_t (x, y, z)
//   result    out        result_valid/result_ready result_t (left, right, z)
//   cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One target per cycle while the output is not stalled; the pipeline is
// two front stages (offsets and squares, then sums) and one root cell per length bit.
// Every stage has its own valid and fills a bubble ahead of it, so targets keep
// entering while a finished result waits for result_ready.
// Reset clears all valid bits and the three anchor registers to zero.
// cfg_ready is always high; an index past the register list is ignored.
`default_nettype none
module polargraph_belt_lengths import pbl_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                target_valid,
	output logic                     target_ready,
	input  wire target_t             target,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output result_t                  result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [POS_BITS-1:0] cfg_data
);

	logic [POS_BITS-1:0] left_edge_x_q, right_edge_x_q, top_edge_y_q;

	logic       chain_valid [LEN_BITS+1];
	logic       chain_ready [LEN_BITS+1];
	cell_data_t chain_data  [LEN_BITS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_x_q  <= '0;
			right_edge_x_q <= '0;
			top_edge_y_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEFT_EDGE_X:  left_edge_x_q  <= cfg_data;
				REG_RIGHT_EDGE_X: right_edge_x_q <= cfg_data;
				REG_TOP_EDGE_Y:   top_edge_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	pbl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.left_edge_x  (left_edge_x_q),
		.right_edge_x (right_edge_x_q),
		.top_edge_y   (top_edge_y_q),
		.up_valid     (target_valid),
		.up_ready     (target_ready),
		.up_data      (target),
		.dn_valid     (chain_valid[0]),
		.dn_ready     (chain_ready[0]),
		.dn_data      (chain_data[0])
	);

	for (genvar i = 0; i < LEN_BITS; i++) begin : g_cell
		pbl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	// the last cell's register is the output register
	assign chain_ready[LEN_BITS] = result_ready;
	assign result_valid          = chain_valid[LEN_BITS];
	assign result.left_belt_length  = chain_data[LEN_BITS].left.root;
	assign result.right_belt_length = chain_data[LEN_BITS].right.root;
	assign result.out_z             = chain_data[LEN_BITS].z;

endmodule
`default_nettype wire

// ===== hdl/pbl_checker.sv =====
// Port-level checks for the belt length block, bound to the top level.
`default_nettype none
module pbl_checker import pbl_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    target_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result,
	input wire logic    cfg_valid,
	input wire logic    cfg_ready
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// an empty output means every stage can move, so input is open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> target_ready)
		else $error("target_ready low with no result pending");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.left_belt_length <= LEN_MAX
			&& result.right_belt_length <= LEN_MAX)
		else $error("belt length above full-scale diagonal");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind polargraph_belt_lengths pbl_checker u_pbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.target_ready (target_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
`default_nettype wire
